// ===== rtl/core/ptw_pkg.sv =====
// ptw_pkg: shared types, codes and sizes of the pre-order tree walker
// no dependencies; imported by the controller, the datapath and the top level
package ptw_pkg;

  localparam int MAX_NODES = 256;
  localparam int NODE_W    = 8;
  localparam int ADDR_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = 2;
  localparam int IN_DATA_W = 40;
  localparam int IN_USER_W = 2;

  typedef logic [NODE_W-1:0] node_idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  localparam cnt_t CNT_ZERO  = 2'd0;
  localparam cnt_t CNT_ONE   = 2'd1;
  localparam cnt_t CNT_TWO   = 2'd2;
  localparam cnt_t CNT_THREE = 2'd3;

  typedef enum logic [1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_RESTART = 2'd1,
    FUNC_NEXT    = 2'd2
  } func_e_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL
  } state_t;

  // one row of the node tables
  typedef struct packed {
    node_idx_t parent;
    node_idx_t right;
    logic      leaf;
    node_idx_t left;
  } node_t;

  // load request fields as they arrive on the input channel
  typedef struct packed {
    node_idx_t parent_link;
    node_idx_t right_link;
    logic      has_left;
    node_idx_t left_link;
    node_idx_t node_index;
  } load_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic restart;
    logic rd;
    logic commit;
    logic emit_end;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_full;
    logic end_now;
    logic first_visit;
  } stat_t;

  function automatic logic in_range(input node_idx_t idx);
    return {1'b0, idx} < (NODE_W + 1)'(MAX_NODES);
  endfunction

endpackage

// ===== rtl/core/ptw_ctrl.sv =====
// ptw_ctrl: sequencer of the walker, a read state and an evaluate state per visit
// depends on ptw_pkg
module ptw_ctrl import ptw_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  func_e_t func,
  input  stat_t   stat,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          case (func)
            FUNC_LOAD:    cmd.load = 1'b1;
            FUNC_RESTART: cmd.restart = 1'b1;
            FUNC_NEXT:    state_nxt = ST_READ;
            default:      ;
          endcase
        end
      end
      ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        // hold while the previous result is still unclaimed
        if (!stat.out_full) begin
          if (stat.end_now) begin
            cmd.emit_end = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            cmd.commit = 1'b1;
            state_nxt  = stat.first_visit ? ST_IDLE : ST_READ;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/ptw_datapath.sv =====
// ptw_datapath: node tables, visit counters, cursor and result register
// depends on ptw_pkg; driven by ptw_ctrl commands
module ptw_datapath import ptw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      cmd,
  output stat_t     stat,
  input  load_t     load,
  input  logic      cfg_valid,
  input  node_idx_t cfg_data,
  input  logic      out_tready,
  output logic      out_tvalid,
  output node_idx_t out_node,
  output logic      out_done
);

  node_t     node_mem_r [MAX_NODES];
  cnt_t      cnt_mem_r  [MAX_NODES];
  logic      cnt_vld_r  [MAX_NODES];
  node_t     node_rd_r;
  cnt_t      cnt_rd_r;
  logic      vld_rd_r;
  node_idx_t cursor_r, cursor_nxt;
  logic      finished_r, finished_nxt;
  node_idx_t root_r;
  logic      out_valid_r;
  node_idx_t out_node_r;
  logic      out_done_r;
  cnt_t      cnt_eff;
  logic      is_root;
  logic      first;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r <= '0;
    end else if (cfg_valid) begin
      root_r <= cfg_data;
    end
  end

  // node tables
  always_ff @(posedge clk) begin
    if (cmd.load && in_range(load.node_index)) begin
      node_mem_r[load.node_index[ADDR_W-1:0]] <= '{parent: load.parent_link,
                                                   right:  load.right_link,
                                                   leaf:   ~load.has_left,
                                                   left:   load.left_link};
    end
    if (cmd.rd) begin
      node_rd_r <= node_mem_r[cursor_r[ADDR_W-1:0]];
    end
  end

  // visit counters; a clear flag marks an entry as zero
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      cnt_mem_r[cursor_r[ADDR_W-1:0]] <= cnt_eff + CNT_ONE;
    end
    if (cmd.rd) begin
      cnt_rd_r <= cnt_mem_r[cursor_r[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.restart) begin
      for (int i = 0; i < MAX_NODES; i++) begin
        cnt_vld_r[i] <= 1'b0;
      end
    end else if (cmd.commit) begin
      cnt_vld_r[cursor_r[ADDR_W-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_rd_r <= 1'b0;
    end else if (cmd.rd) begin
      vld_rd_r <= cnt_vld_r[cursor_r[ADDR_W-1:0]];
    end
  end

  assign cnt_eff = vld_rd_r ? cnt_rd_r : CNT_ZERO;
  assign is_root = (cursor_r == root_r);
  assign first   = (cnt_eff == CNT_ZERO);

  assign stat.first_visit = first;
  assign stat.end_now     = finished_r || !in_range(cursor_r) || (cnt_eff == CNT_THREE)
                            || ((cnt_eff == CNT_TWO) && is_root);
  assign stat.out_full    = out_valid_r && !out_tready;

  // cursor moves
  always_comb begin
    cursor_nxt   = cursor_r;
    finished_nxt = finished_r;
    if (cmd.restart) begin
      cursor_nxt   = root_r;
      finished_nxt = 1'b0;
    end else if (cmd.emit_end) begin
      finished_nxt = 1'b1;
    end else if (cmd.commit) begin
      case (cnt_eff)
        CNT_ZERO: begin
          if (!node_rd_r.leaf) begin
            cursor_nxt = node_rd_r.left;
          end else if (is_root) begin
            finished_nxt = 1'b1;
          end else begin
            cursor_nxt = node_rd_r.parent;
          end
        end
        CNT_ONE: cursor_nxt = node_rd_r.right;
        default: cursor_nxt = node_rd_r.parent;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r   <= '0;
      finished_r <= 1'b0;
    end else begin
      cursor_r   <= cursor_nxt;
      finished_r <= finished_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_end || (cmd.commit && first)) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_end) begin
      out_node_r <= '0;
      out_done_r <= 1'b1;
    end else if (cmd.commit && first) begin
      out_node_r <= cursor_r;
      out_done_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_node   = out_node_r;
  assign out_done   = out_done_r;

endmodule

// ===== rtl/core/preorder_tree_walker.sv =====
// preorder_tree_walker: top level, depth-first pre-order walk over node tables
// depends on ptw_pkg, ptw_ctrl and ptw_datapath
//
//  channel  | direction | data                         | side band
//  ---------+-----------+------------------------------+-----------------
//  in_      | slave     | links of a load request      | tuser = func
//  out_     | master    | node_out                     | tuser = walk_done
//  cfg_     | slave     | subtree_root                 | none
//
// load, restart and unknown requests are done in the idle state, which they do not leave
// a next request walks visits until a first visit or the end: each visit is
// a node-table read state followed by an evaluate state that writes the visit
// counter and moves the cursor, or that marks the end of the walk
// restart clears the counter flags at once, there is no clearing pass
// the result register lets the next request in while a result is unclaimed;
// a further result waits in the evaluate cycle until out_tready frees it
// reset (rst_n low, synchronous) clears cursor, end flag, root and flags
module preorder_tree_walker import ptw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // node_index[7:0] left_link[15:8] has_left[16] right_link[24:17]
  // parent_link[32:25], zero pad[39:33]
  input  logic [IN_DATA_W-1:0] in_tdata,
  // func[1:0]
  input  logic [IN_USER_W-1:0] in_tuser,
  // configuration write
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  // subtree_root[7:0]
  input  logic [NODE_W-1:0]    cfg_data,
  // result channel
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // node_out[7:0]
  output logic [NODE_W-1:0]    out_tdata,
  // walk_done[0]
  output logic                 out_tuser
);

  cmd_t    cmd;
  stat_t   stat;
  load_t   load;
  func_e_t func;

  // unpack the request; padding bits are dropped
  assign load = load_t'(in_tdata[$bits(load_t)-1:0]);
  assign func = func_e_t'(in_tuser);

  // register writes must arrive only while idle, which the block itself does not enforce; cfg_ready is tied high
  assign cfg_ready = 1'b1;

  ptw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .func      (func),
    .stat      (stat),
    .cmd       (cmd)
  );

  ptw_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .load       (load),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_node   (out_tdata),
    .out_done   (out_tuser)
  );

endmodule
